// ----- hw/rtl/clns_pkg.sv -----
package clns_pkg;

  // width of every delay register and wait counter
  localparam int unsigned DELAY_BITS = 17;
  typedef logic [DELAY_BITS-1:0] delay_t;

  // apb register window
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W  = REG_IDX_W + 2;

  // request codes carried in the action field
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_INIT = 2'd1,
    ACT_CMD  = 2'd2,
    ACT_DATA = 2'd3
  } action_e;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE_WIDTH   = 3'd0,
    REG_POWER_UP_WAIT  = 3'd1,
    REG_INIT_WAIT      = 3'd2,
    REG_COMMAND_SETTLE = 3'd3,
    REG_DATA_SETTLE    = 3'd4,
    REG_SHORT_WAIT     = 3'd5,
    REG_CLEAR_WAIT     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    delay_t enable_width;
    delay_t power_up_wait;
    delay_t init_wait;
    delay_t command_settle;
    delay_t data_settle;
    delay_t short_wait;
    delay_t clear_wait;
  } cfg_t;

  // register reset values, truncated to the counter width
  localparam delay_t EnableWidthRst   = delay_t'(25);
  localparam delay_t PowerUpWaitRst   = delay_t'(3200);
  localparam delay_t InitWaitRst      = delay_t'(30000);
  localparam delay_t CommandSettleRst = delay_t'(1000);
  localparam delay_t DataSettleRst    = delay_t'(100000);
  localparam delay_t ShortWaitRst     = delay_t'(800);
  localparam delay_t ClearWaitRst     = delay_t'(10000);

  // one input transaction
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    delay_t     extra_wait;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic [3:0] data_nibble;
    logic       reg_select;
    logic       enable;
    logic       busy_res;
    logic       accepted;
  } res_t;

  // handshake between input register and sequencer core
  typedef struct packed {
    logic valid;
    req_t item;
  } item_ctl_t;

  // init sequence step numbering
  localparam logic [3:0] InitStepNone     = 4'd0;
  localparam logic [3:0] InitStepRawFirst = 4'd1;
  localparam logic [3:0] InitStepRawLast  = 4'd4;
  localparam logic [3:0] InitStepCmdFirst = 4'd5;
  localparam logic [3:0] InitStepCmdLast  = 4'd9;

  localparam logic [7:0] InitByteThree = 8'h30;
  localparam logic [7:0] InitByteTwo   = 8'h20;

  // pin vector layout: enable, register select, data nibble
  localparam int unsigned EnBit = 5;
  localparam int unsigned RsBit = 4;

  // zero-length phases that can fall through within one transaction
  localparam int unsigned MaxChain = 3;

  // init command bytes, in order
  function automatic logic [7:0] init_cmd(logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h06;
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h80;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  // extra wait after each init command
  function automatic delay_t init_extra(logic [2:0] k, cfg_t c);
    delay_t w;
    unique case (k)
      3'd0:    w = c.init_wait;
      3'd3:    w = c.clear_wait;
      default: w = c.short_wait;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/clns_req_if.sv -----
interface clns_req_if import clns_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_value;
  delay_t     extra_wait;

  modport source (output valid, action, byte_value, extra_wait, input ready);
  modport sink   (input valid, action, byte_value, extra_wait, output ready);
endinterface

// ----- hw/rtl/clns_res_if.sv -----
interface clns_res_if import clns_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       reg_select;
  logic       enable;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, data_nibble, reg_select, enable, busy_res, accepted,
                  input ready);
  modport sink   (input valid, data_nibble, reg_select, enable, busy_res, accepted,
                  output ready);
endinterface

// ----- hw/rtl/clns_apb_regs.sv -----
module clns_apb_regs import clns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // register writes, access phase only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_width   <= EnableWidthRst;
      cfg_q.power_up_wait  <= PowerUpWaitRst;
      cfg_q.init_wait      <= InitWaitRst;
      cfg_q.command_settle <= CommandSettleRst;
      cfg_q.data_settle    <= DataSettleRst;
      cfg_q.short_wait     <= ShortWaitRst;
      cfg_q.clear_wait     <= ClearWaitRst;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE_WIDTH:   cfg_q.enable_width   <= pwdata[DELAY_BITS-1:0];
        REG_POWER_UP_WAIT:  cfg_q.power_up_wait  <= pwdata[DELAY_BITS-1:0];
        REG_INIT_WAIT:      cfg_q.init_wait      <= pwdata[DELAY_BITS-1:0];
        REG_COMMAND_SETTLE: cfg_q.command_settle <= pwdata[DELAY_BITS-1:0];
        REG_DATA_SETTLE:    cfg_q.data_settle    <= pwdata[DELAY_BITS-1:0];
        REG_SHORT_WAIT:     cfg_q.short_wait     <= pwdata[DELAY_BITS-1:0];
        REG_CLEAR_WAIT:     cfg_q.clear_wait     <= pwdata[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ENABLE_WIDTH:   prdata = PDATA_W'(cfg_q.enable_width);
      REG_POWER_UP_WAIT:  prdata = PDATA_W'(cfg_q.power_up_wait);
      REG_INIT_WAIT:      prdata = PDATA_W'(cfg_q.init_wait);
      REG_COMMAND_SETTLE: prdata = PDATA_W'(cfg_q.command_settle);
      REG_DATA_SETTLE:    prdata = PDATA_W'(cfg_q.data_settle);
      REG_SHORT_WAIT:     prdata = PDATA_W'(cfg_q.short_wait);
      REG_CLEAR_WAIT:     prdata = PDATA_W'(cfg_q.clear_wait);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/clns_in_reg.sv -----
module clns_in_reg import clns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clns_req_if.sink   req_i,
  input  logic       take_i,
  output item_ctl_t  item_o
);

  logic valid_q;
  req_t item_q;
  logic load;

  // slot frees when empty or when the core takes the held transaction
  assign req_i.ready = !valid_q || take_i;
  assign load        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.action     <= req_i.action;
      item_q.byte_value <= req_i.byte_value;
      item_q.extra_wait <= req_i.extra_wait;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.item  = item_q;

endmodule

// ----- hw/rtl/clns_seq_core.sv -----
module clns_seq_core import clns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_ctl_t  item_i,
  output logic       take_o,
  clns_res_if.source res_o
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_POWER      = 3'd1,
    PH_RAW_STROBE = 3'd2,
    PH_RAW_WAIT   = 3'd3,
    PH_STROBE_HI  = 3'd4,
    PH_STROBE_LO  = 3'd5,
    PH_SETTLE     = 3'd6,
    PH_EXTRA      = 3'd7
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    delay_t     wait_count;
    logic [7:0] pend_byte;
    logic       pend_sel;
    delay_t     pend_extra;
    logic [3:0] init_step;
    logic [5:0] pins;
  } seq_t;

  seq_t st_q;
  seq_t st_d;
  res_t res_q;
  res_t res_d;
  logic res_valid_q;
  logic taken;
  logic fire;

  // put a nibble on the bus with enable raised
  function automatic seq_t start_strobe(seq_t s, phase_e ph, logic [3:0] nib,
                                        delay_t en_w);
    seq_t r;
    r            = s;
    r.phase      = ph;
    r.pins       = {1'b1, s.pend_sel, nib};
    r.wait_count = (en_w == '0) ? delay_t'(1) : en_w;
    return r;
  endfunction

  // load the init item selected by init_step, or finish the sequence
  function automatic seq_t begin_item(seq_t s, cfg_t c);
    seq_t       r;
    logic [2:0] k;
    r = s;
    k = 3'(s.init_step - InitStepCmdFirst);
    if (s.init_step >= InitStepRawFirst && s.init_step <= InitStepRawLast) begin
      r.pend_byte = (s.init_step == InitStepRawLast) ? InitByteTwo : InitByteThree;
      r.pend_sel  = 1'b0;
      r = start_strobe(r, PH_RAW_STROBE, r.pend_byte[7:4], c.enable_width);
    end else if (s.init_step >= InitStepCmdFirst && s.init_step <= InitStepCmdLast) begin
      r.pend_byte  = init_cmd(k);
      r.pend_sel   = 1'b0;
      r.pend_extra = init_extra(k, c);
      r = start_strobe(r, PH_STROBE_HI, r.pend_byte[7:4], c.enable_width);
    end else begin
      r.init_step  = InitStepNone;
      r.phase      = PH_IDLE;
      r.wait_count = '0;
    end
    return r;
  endfunction

  // leave a phase whose count has run out
  function automatic seq_t advance(seq_t s, cfg_t c);
    seq_t r;
    r = s;
    unique case (s.phase)
      PH_POWER: begin
        r.init_step = InitStepRawFirst;
        r = begin_item(r, c);
      end
      PH_RAW_STROBE, PH_STROBE_HI, PH_STROBE_LO: begin
        if (s.pins[EnBit]) begin
          r.pins[EnBit] = 1'b0;
          r.wait_count  = delay_t'(1);
        end else if (s.phase == PH_RAW_STROBE) begin
          r.phase      = PH_RAW_WAIT;
          r.wait_count = c.init_wait;
        end else if (s.phase == PH_STROBE_HI) begin
          r = start_strobe(r, PH_STROBE_LO, s.pend_byte[3:0], c.enable_width);
        end else begin
          r.phase      = PH_SETTLE;
          r.wait_count = s.pend_sel ? c.data_settle : c.command_settle;
        end
      end
      PH_RAW_WAIT: begin
        r.init_step = s.init_step + 4'd1;
        r = begin_item(r, c);
      end
      PH_SETTLE: begin
        r.phase      = PH_EXTRA;
        r.wait_count = s.pend_extra;
      end
      PH_EXTRA: begin
        if (s.init_step != InitStepNone) begin
          r.init_step = s.init_step + 4'd1;
          r = begin_item(r, c);
        end else begin
          r.phase      = PH_IDLE;
          r.wait_count = '0;
        end
      end
      PH_IDLE: begin
        r.phase      = PH_IDLE;
        r.wait_count = '0;
      end
    endcase
    return r;
  endfunction

  // result slot frees when empty or when the sink takes it
  assign take_o = !res_valid_q || res_o.ready;
  assign fire   = item_i.valid && take_o;

  // one transaction: tick or request, then fall through exhausted phases
  always_comb begin
    st_d  = st_q;
    taken = 1'b0;
    if (item_i.item.action == ACT_TICK) begin
      if (st_q.phase != PH_IDLE && st_q.wait_count != '0) begin
        st_d.wait_count = st_q.wait_count - delay_t'(1);
      end
    end else if (st_q.phase == PH_IDLE) begin
      taken          = 1'b1;
      st_d.init_step = InitStepNone;
      if (item_i.item.action == ACT_INIT) begin
        st_d.phase      = PH_POWER;
        st_d.pins       = '0;
        st_d.wait_count = cfg_i.power_up_wait;
      end else begin
        st_d.pend_byte  = item_i.item.byte_value;
        st_d.pend_sel   = (item_i.item.action == ACT_DATA);
        st_d.pend_extra = (item_i.item.action == ACT_DATA) ? '0 : item_i.item.extra_wait;
        st_d = start_strobe(st_d, PH_STROBE_HI, item_i.item.byte_value[7:4],
                            cfg_i.enable_width);
      end
    end
    for (int i = 0; i < MaxChain; i++) begin
      if (st_d.phase != PH_IDLE && st_d.wait_count == '0) begin
        st_d = advance(st_d, cfg_i);
      end
    end
  end

  // result fields from the updated pin levels
  always_comb begin
    res_d.data_nibble = st_d.pins[3:0];
    res_d.reg_select  = st_d.pins[RsBit];
    res_d.enable      = st_d.pins[EnBit];
    res_d.busy_res    = (st_d.phase != PH_IDLE);
    res_d.accepted    = taken;
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (fire) begin
        st_q  <= st_d;
        res_q <= res_d;
      end
      if (take_o) begin
        res_valid_q <= item_i.valid;
      end
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.data_nibble = res_q.data_nibble;
  assign res_o.reg_select  = res_q.reg_select;
  assign res_o.enable      = res_q.enable;
  assign res_o.busy_res    = res_q.busy_res;
  assign res_o.accepted    = res_q.accepted;

endmodule

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
// Character LCD sequencer for a 4-bit HD44780-style bus. Every input transaction
// is either a tick, which moves time on by one step, or a request (power-up init,
// command byte, data byte) that is taken only while the sequencer is idle; each
// transaction yields exactly one result carrying the bus levels, busy and whether
// the request was accepted. One transaction is taken per clock cycle with no
// bubbles while results are accepted; a result is presented once its transaction
// has passed the input register and then the sequencer state and result register,
// and while a result waits unaccepted the input register holds and the input
// stalls. All waits and enable pulse lengths are counted in ticks, as set
// by the seven APB delay registers at byte addresses 0x00 to 0x18; they should be
// written only while the sequencer is idle.
module char_lcd_nibble_sequencer import clns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  clns_req_if.sink           req_i,
  clns_res_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  item_ctl_t item;
  logic      take;

  // delay registers
  clns_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  clns_in_reg u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .take_i (take),
    .item_o (item)
  );

  // sequencer state and result register
  clns_seq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item),
    .take_o (take),
    .res_o  (res_o)
  );

endmodule
